### sv/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the frame average color fade core.
// ----------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

   localparam int CHAN_W    = 8;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 2;
   localparam int SKIP_W    = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_AMOUNT  = 2'd2;

   localparam logic [CSR_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
   localparam logic [CSR_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
   localparam logic [SKIP_W-1:0] SKIP_AMOUNT_RST  = 8'd15;

   localparam int AVG_BITS = 8;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              first_pixel;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              last_step;
   } color_type;

   typedef struct packed {
      logic       pixel;
      logic       recalc_init;
      logic       recalc_step;
      logic       avg_step;
      logic       diff_step;
      logic       ramp_step;
      logic       ramp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic skip_written;
   } dp_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RECALC = 5'b00010,
      ST_AVG    = 5'b00100,
      ST_DIFF   = 5'b01000,
      ST_RAMP   = 5'b10000
   } ctrl_state_type;

endpackage

`default_nettype wire

### sv/frame_average_color_fade_core.sv
// ----------------------------------------------------------------------------
// frame_average_color_fade_core
// Subsampled per-frame average color with a linear fade toward it.
// ----------------------------------------------------------------------------
// Pixels come in raster order on req_pixel and are taken at a clock edge
// where start is high and busy is low, so pixels stream at one per cycle
// while busy stays low. The item that closes a frame starts the frame-end
// work, with busy high throughout: a shift-subtract average divide, a step
// dividing each color delta by RAMP_STEPS, then one fade color per cycle.
// Fade colors show on rsp_color with rsp_valid high for one cycle each; the
// last one carries last_step. The receiver cannot stall, every result is
// taken in the cycle it is shown. csr_we writes frame_width, frame_height
// or skip_amount with no wait. After a skip_amount write the sampling
// phases are recomputed from the current column and row, busy high
// meanwhile. Reset (synchronous) restores the register defaults, clears
// counters and sums and sets the current color to black.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_average_color_fade_core #(
   parameter int MAX_DIM    = 4096,
   parameter int RAMP_STEPS = 60
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire fac_pkg::pixel_type            req_pixel,
   input  wire logic                          csr_we,
   input  wire logic [fac_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fac_pkg::CSR_W-1:0]     csr_wdata,
   output logic                               rsp_valid,
   output fac_pkg::color_type                 rsp_color
);
   import fac_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fac_ctrl #(
      .MAX_DIM    (MAX_DIM),
      .RAMP_STEPS (RAMP_STEPS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fac_dp #(
      .MAX_DIM    (MAX_DIM),
      .RAMP_STEPS (RAMP_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_pixel (req_pixel),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_color (rsp_color)
   );

endmodule

`default_nettype wire

### sv/fac_ctrl.sv
// ----------------------------------------------------------------------------
// fac_ctrl
// Sequencer: pixel accept, phase recompute, average divide, fade step
// divide and fade ramp output.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_ctrl #(
   parameter int MAX_DIM    = 4096,
   parameter int RAMP_STEPS = 60
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire fac_pkg::dp_stat_type stat,
   output fac_pkg::dp_cmd_type       cmd
);
   import fac_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int IT_A   = (CNT_W > AVG_BITS) ? CNT_W : AVG_BITS;
   localparam int IT_MAX = (RAMP_STEPS > IT_A) ? RAMP_STEPS : IT_A;
   localparam int IT_W   = $clog2(IT_MAX);

   localparam logic [IT_W-1:0] REC_LAST  = IT_W'(CNT_W - 1);
   localparam logic [IT_W-1:0] DIV_LAST  = IT_W'(AVG_BITS - 1);
   localparam logic [IT_W-1:0] RAMP_LAST = IT_W'(RAMP_STEPS - 1);

   ctrl_state_type  state_ff, state_in;
   logic [IT_W-1:0] iter_ff, iter_in;
   logic            dirty_ff, dirty_in;
   logic            accept;

   assign busy   = (state_ff != ST_IDLE) || dirty_ff;
   assign accept = start && !busy;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      iter_in  = iter_ff;
      dirty_in = dirty_ff || stat.skip_written;
      case (state_ff)
         ST_IDLE: begin
            if (dirty_ff) begin
               cmd.recalc_init = 1'b1;
               state_in        = ST_RECALC;
               iter_in         = '0;
               dirty_in        = stat.skip_written;
            end else if (accept) begin
               cmd.pixel = 1'b1;
               if (stat.frame_end) begin
                  state_in = ST_AVG;
                  iter_in  = '0;
               end
            end
         end
         ST_RECALC: begin
            cmd.recalc_step = 1'b1;
            iter_in         = iter_ff + IT_W'(1);
            if (iter_ff == REC_LAST) begin
               state_in = ST_IDLE;
               iter_in  = '0;
            end
         end
         ST_AVG: begin
            cmd.avg_step = 1'b1;
            iter_in      = iter_ff + IT_W'(1);
            if (iter_ff == DIV_LAST) begin
               state_in = ST_DIFF;
               iter_in  = '0;
            end
         end
         ST_DIFF: begin
            cmd.diff_step = 1'b1;
            state_in      = ST_RAMP;
            iter_in       = '0;
         end
         ST_RAMP: begin
            cmd.ramp_step = 1'b1;
            iter_in       = iter_ff + IT_W'(1);
            if (iter_ff == RAMP_LAST) begin
               cmd.ramp_last = 1'b1;
               state_in      = ST_IDLE;
               iter_in       = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            iter_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         dirty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         dirty_ff <= dirty_in;
      end
   end

   a_avg_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_AVG) |-> $past(accept && stat.frame_end))
      else $error("divide started without a frame end item");

   a_diff_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |=> (state_ff == ST_RAMP))
      else $error("delta divide did not hand over to the fade ramp");

   a_ramp_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RAMP && iter_ff == RAMP_LAST) |=> (state_ff == ST_IDLE))
      else $error("fade ramp did not finish after its last step");

endmodule

`default_nettype wire

### sv/fac_dp.sv
// ----------------------------------------------------------------------------
// fac_dp
// Datapath: config registers, raster counters, channel sums, shift-subtract
// dividers and the incremental fade ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_dp #(
   parameter int MAX_DIM    = 4096,
   parameter int RAMP_STEPS = 60
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [fac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fac_pkg::CSR_W-1:0]          csr_wdata,
   input  wire fac_pkg::pixel_type                 req_pixel,
   input  wire fac_pkg::dp_cmd_type                cmd,
   output fac_pkg::dp_stat_type                    stat,
   output logic                                    rsp_valid,
   output fac_pkg::color_type                      rsp_color
);
   import fac_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = CNT_W + 1;
   localparam int SCNT_W = 2 * CNT_W + 1;
   localparam int SUM_W  = SCNT_W + AVG_BITS - 1;
   localparam int RW     = $clog2(RAMP_STEPS + 1);

   // reciprocal of RAMP_STEPS, exact for every 8-bit delta
   localparam int RCP_S  = CHAN_W + $clog2(RAMP_STEPS);
   localparam int PROD_W = RCP_S + CHAN_W;
   localparam logic [CHAN_W:0] RCP_M =
      (CHAN_W + 1)'(((1 << RCP_S) + RAMP_STEPS - 1) / RAMP_STEPS);

   localparam logic [CSR_W-1:0] MAX_DIM_C = CSR_W'(MAX_DIM);
   localparam logic [RW:0]      RAMP_C    = (RW + 1)'(RAMP_STEPS);

   // config
   logic [CSR_W-1:0]  width_ff, height_ff;
   logic [SKIP_W-1:0] skip_ff;

   // raster tracking and sums
   logic [CNT_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [SKIP_W-1:0] cph_ff, cph_in, rph_ff, rph_in;
   logic [CNT_W-1:0]  col_sh_ff, col_sh_in, row_sh_ff, row_sh_in;
   logic [SUM_W-1:0]  sum_ff [3];
   logic [SUM_W-1:0]  sum_in [3];
   logic [SCNT_W-1:0] cnt_ff, cnt_in;

   // dividers and ramp
   logic [SUM_W-1:0]  rem_ff [3];
   logic [SUM_W-1:0]  rem_in [3];
   logic [SUM_W-1:0]  div_ff, div_in;
   logic              cnt_zero_ff, cnt_zero_in;
   logic [CHAN_W-1:0] avg_ff [3];
   logic [CHAN_W-1:0] avg_in [3];
   logic [CHAN_W-1:0] cur_ff [3];
   logic [CHAN_W-1:0] cur_in [3];
   logic [RW-1:0]     drem_ff [3];
   logic [RW-1:0]     drem_in [3];
   logic [CHAN_W-1:0] dq_ff [3];
   logic [CHAN_W-1:0] dq_in [3];
   logic [RW-1:0]     r_ff [3];
   logic [RW-1:0]     r_in [3];
   logic [CHAN_W-1:0] q_ff [3];
   logic [CHAN_W-1:0] q_in [3];
   logic [CHAN_W-1:0] val [3];
   logic              rsp_valid_ff;
   color_type         rsp_color_ff, rsp_color_in;

   // pixel path
   logic [CSR_W-1:0]  w_clamp, h_clamp;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [CNT_W-1:0]  col_cur, row_cur;
   logic [SKIP_W-1:0] cph_cur, rph_cur, cph_nx, rph_nx;
   logic [SUM_W-1:0]  sum_nx [3];
   logic [SCNT_W-1:0] cnt_cur, cnt_nx;
   logic [CHAN_W-1:0] px [3];
   logic              sampled, row_end, frame_end;

   // phase recompute
   logic [SKIP_W:0]   step9, ct, rt;

   always_comb begin
      w_clamp = (width_ff == '0) ? CSR_W'(1) :
                (width_ff > MAX_DIM_C) ? MAX_DIM_C : width_ff;
      h_clamp = (height_ff == '0) ? CSR_W'(1) :
                (height_ff > MAX_DIM_C) ? MAX_DIM_C : height_ff;
      w_eff   = w_clamp[DIM_W-1:0];
      h_eff   = h_clamp[DIM_W-1:0];

      px[0] = req_pixel.red;
      px[1] = req_pixel.green;
      px[2] = req_pixel.blue;

      col_cur = req_pixel.first_pixel ? '0 : col_ff;
      row_cur = req_pixel.first_pixel ? '0 : row_ff;
      cph_cur = req_pixel.first_pixel ? '0 : cph_ff;
      rph_cur = req_pixel.first_pixel ? '0 : rph_ff;
      cnt_cur = req_pixel.first_pixel ? '0 : cnt_ff;
      sampled = (cph_cur == '0) && (rph_cur == '0);
      for (int i = 0; i < 3; i++) begin
         sum_nx[i] = (req_pixel.first_pixel ? '0 : sum_ff[i]) +
                     (sampled ? SUM_W'(px[i]) : '0);
      end
      cnt_nx = cnt_cur + SCNT_W'(sampled);

      row_end   = ({1'b0, col_cur} + DIM_W'(1)) >= w_eff;
      frame_end = row_end && (({1'b0, row_cur} + DIM_W'(1)) >= h_eff);
      cph_nx    = (cph_cur == skip_ff) ? '0 : cph_cur + SKIP_W'(1);
      rph_nx    = (rph_cur == skip_ff) ? '0 : rph_cur + SKIP_W'(1);

      step9 = {1'b0, skip_ff} + (SKIP_W + 1)'(1);
      ct    = {cph_ff, col_sh_ff[CNT_W-1]};
      rt    = {rph_ff, row_sh_ff[CNT_W-1]};
   end

   assign stat.frame_end    = frame_end;
   assign stat.skip_written = csr_we && (csr_index == CSR_SKIP_AMOUNT);

   // counters, sums and phases
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      cph_in    = cph_ff;
      rph_in    = rph_ff;
      col_sh_in = col_sh_ff;
      row_sh_in = row_sh_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      if (cmd.pixel) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            cph_in = '0;
            rph_in = '0;
            cnt_in = '0;
            for (int i = 0; i < 3; i++) sum_in[i] = '0;
         end else begin
            cnt_in = cnt_nx;
            sum_in = sum_nx;
            if (row_end) begin
               col_in = '0;
               row_in = row_cur + CNT_W'(1);
               cph_in = '0;
               rph_in = rph_nx;
            end else begin
               col_in = col_cur + CNT_W'(1);
               row_in = row_cur;
               cph_in = cph_nx;
               rph_in = rph_cur;
            end
         end
      end else if (cmd.recalc_init) begin
         col_sh_in = col_ff;
         row_sh_in = row_ff;
         cph_in    = '0;
         rph_in    = '0;
      end else if (cmd.recalc_step) begin
         col_sh_in = col_sh_ff << 1;
         row_sh_in = row_sh_ff << 1;
         cph_in    = (ct >= step9) ? SKIP_W'(ct - step9) : ct[SKIP_W-1:0];
         rph_in    = (rt >= step9) ? SKIP_W'(rt - step9) : rt[SKIP_W-1:0];
      end
   end

   // average divide, fade step divide, ramp
   always_comb begin
      logic              ge;
      logic [CHAN_W-1:0] absd;
      logic              neg;
      logic [PROD_W-1:0] prod;
      logic [CHAN_W-1:0] quo;
      logic [RW:0]       rs;
      logic              c;
      ge           = 1'b0;
      rs           = '0;
      c            = 1'b0;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_zero_in  = cnt_zero_ff;
      avg_in       = avg_ff;
      cur_in       = cur_ff;
      drem_in      = drem_ff;
      dq_in        = dq_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      rsp_color_in = rsp_color_ff;
      for (int i = 0; i < 3; i++) val[i] = cur_ff[i];

      if (cmd.pixel && frame_end) begin
         rem_in      = sum_nx;
         div_in      = {cnt_nx, {(AVG_BITS - 1){1'b0}}};
         cnt_zero_in = (cnt_nx == '0);
         for (int i = 0; i < 3; i++) begin
            drem_in[i] = '0;
            r_in[i]    = '0;
            q_in[i]    = '0;
         end
      end

      if (cmd.avg_step) begin
         div_in = div_ff >> 1;
         for (int i = 0; i < 3; i++) begin
            ge        = rem_ff[i] >= div_ff;
            rem_in[i] = ge ? rem_ff[i] - div_ff : rem_ff[i];
            avg_in[i] = {avg_ff[i][CHAN_W-2:0], ge && !cnt_zero_ff};
         end
      end

      for (int i = 0; i < 3; i++) begin
         neg  = avg_ff[i] < cur_ff[i];
         absd = neg ? cur_ff[i] - avg_ff[i] : avg_ff[i] - cur_ff[i];
         prod = PROD_W'(absd) * PROD_W'(RCP_M);
         quo  = prod[RCP_S +: CHAN_W];
         if (cmd.diff_step) begin
            dq_in[i]   = quo;
            drem_in[i] = RW'(absd - CHAN_W'(quo * RAMP_STEPS));
         end
         if (cmd.ramp_step) begin
            rs      = {1'b0, r_ff[i]} + {1'b0, drem_ff[i]};
            c       = rs >= RAMP_C;
            r_in[i] = c ? RW'(rs - RAMP_C) : rs[RW-1:0];
            q_in[i] = q_ff[i] + dq_ff[i] + CHAN_W'(c);
            val[i]  = neg ? cur_ff[i] - q_in[i] : cur_ff[i] + q_in[i];
            if (cmd.ramp_last) cur_in[i] = avg_ff[i];
         end
      end

      if (cmd.ramp_step) begin
         rsp_color_in.out_red   = val[0];
         rsp_color_in.out_green = val[1];
         rsp_color_in.out_blue  = val[2];
         rsp_color_in.last_step = cmd.ramp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FRAME_WIDTH_RST;
         height_ff    <= FRAME_HEIGHT_RST;
         skip_ff      <= SKIP_AMOUNT_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         cph_ff       <= '0;
         rph_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
            cur_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               CSR_SKIP_AMOUNT:  skip_ff   <= csr_wdata[SKIP_W-1:0];
               default: begin
               end
            endcase
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         cph_ff       <= cph_in;
         rph_ff       <= rph_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.ramp_step;
         sum_ff       <= sum_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      col_sh_ff    <= col_sh_in;
      row_sh_ff    <= row_sh_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      cnt_zero_ff  <= cnt_zero_in;
      avg_ff       <= avg_in;
      drem_ff      <= drem_in;
      dq_ff        <= dq_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_color = rsp_color_ff;

   a_rsp_from_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.ramp_step))
      else $error("result item without a ramp step");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_color_ff.last_step) |=> !rsp_valid_ff)
      else $error("result item after the last fade step");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.pixel && frame_end) |=> (cnt_ff == '0 && col_ff == '0 && row_ff == '0))
      else $error("frame state not cleared at frame end");

endmodule

`default_nettype wire
